@@ sv/insertion_ordered_set_table_assert.svh @@
// Assertion macros for the insertion-ordered set table.
`ifndef INSERTION_ORDERED_SET_TABLE_ASSERT_SVH
`define INSERTION_ORDERED_SET_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define IOST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked outside reset
`define IOST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define IOST_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define IOST_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ sv/iost_pkg.sv @@
// Shared constants, codes and controller/datapath interface types.
package iost_pkg;

   // Default sizing
   localparam int CAPACITY_DEF   = 16;
   localparam int ELEM_WIDTH_DEF = 32;

   // Fixed port widths
   localparam int ACTION_W    = 3;
   localparam int ELEM_PORT_W = 32;
   localparam int COUNT_W     = 5;
   localparam int STATUS_W    = 2;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_MEMBER = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_GET    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // capture the request, reset scan and result
      logic clear_occ;   // empty the set
      logic issue;       // issue the next table read of a scan
      logic shift;       // write back reads one slot lower
      logic set_found;   // element matched
      logic set_full;    // add refused
      logic mark_empty;  // get on empty set
      logic take_first;  // capture entry zero
      logic append;      // write element at the tail
      logic dec_occ;     // one entry removed
      logic rsp_load;    // load the response register
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [ACTION_W-1:0] act;
      logic                hit;
      logic                scan_done;
      logic                full;
      logic                occ_zero;
   } dp_sts_type;

endpackage

@@ sv/iost_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module iost_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/iost_ctrl.sv @@
// Controller state machine: sequences search, shift, append, get and response.
module iost_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [iost_pkg::ACTION_W-1:0]    req_action,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  iost_pkg::dp_sts_type             sts,
   output iost_pkg::dp_cmd_type             cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_SHIFT  = 3'd2;
   localparam logic [2:0] S_GET    = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Next state and command decode
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_action)
                  iost_pkg::ACT_ADD, iost_pkg::ACT_REMOVE, iost_pkg::ACT_MEMBER: begin
                     state_in = S_SEARCH;
                  end
                  iost_pkg::ACT_GET: begin
                     state_in = S_GET;
                  end
                  iost_pkg::ACT_CLEAR: begin
                     cmd.clear_occ = 1'b1;
                     state_in      = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            cmd.issue = !sts.hit;
            if (sts.hit) begin
               cmd.set_found = 1'b1;
               state_in      = (sts.act == iost_pkg::ACT_REMOVE) ? S_SHIFT : S_RESP;
            end else if (sts.scan_done) begin
               if (sts.act == iost_pkg::ACT_ADD) begin
                  cmd.set_full = sts.full;
                  cmd.append   = !sts.full;
               end
               state_in = S_RESP;
            end
         end
         S_SHIFT: begin
            cmd.issue = 1'b1;
            cmd.shift = 1'b1;
            if (sts.scan_done) begin
               cmd.dec_occ = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_GET: begin
            // entry zero was read while idle
            cmd.mark_empty = sts.occ_zero;
            cmd.take_first = !sts.occ_zero;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid: set on load, dropped when taken
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ sv/iost_dp.sv @@
// Datapath: request registers, occupancy, scan pipeline, table RAM, response register.
module iost_dp #(
   parameter int CAPACITY   = iost_pkg::CAPACITY_DEF,
   parameter int ELEM_WIDTH = iost_pkg::ELEM_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [iost_pkg::ACTION_W-1:0]    req_action,
   input  logic [iost_pkg::ELEM_PORT_W-1:0] req_elem,
   input  iost_pkg::dp_cmd_type             cmd,
   output iost_pkg::dp_sts_type             sts,
   output logic                             rsp_found,
   output logic [iost_pkg::ELEM_PORT_W-1:0] rsp_first_elem,
   output logic [iost_pkg::COUNT_W-1:0]     rsp_count,
   output logic                             rsp_empty_res,
   output logic [iost_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_W  = $clog2(CAPACITY + 1);
   localparam int PortW  = iost_pkg::ELEM_PORT_W;
   localparam int CountW = iost_pkg::COUNT_W;
   localparam logic [OCC_W-1:0] OccFull = OCC_W'(CAPACITY);

   // Control state
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [OCC_W-1:0]  scan_ff, scan_in;
   logic              pend_ff, pend_in;

   // Payload state
   logic [iost_pkg::ACTION_W-1:0] act_ff, act_in;
   logic [ELEM_WIDTH-1:0]         elem_ff, elem_in;
   logic [ADDR_W-1:0]             pend_idx_ff, pend_idx_in;
   logic                          found_ff, found_in;
   logic [iost_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [ELEM_WIDTH-1:0]         first_ff, first_in;

   // Response register
   logic                          rsp_found_ff;
   logic [PortW-1:0]              rsp_first_ff;
   logic [CountW-1:0]             rsp_count_ff;
   logic                          rsp_empty_ff;
   logic [iost_pkg::STATUS_W-1:0] rsp_status_ff;

   // RAM port signals
   logic                  can_issue;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ELEM_WIDTH-1:0] wr_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ELEM_WIDTH-1:0] rd_data;

   iost_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Scan pipeline: one read issued per cycle while cmd.issue is set, below the occupancy
   always_comb begin
      can_issue   = cmd.issue && (scan_ff < occ_ff);
      rd_addr     = can_issue ? scan_ff[ADDR_W-1:0] : '0;
      pend_in     = can_issue;
      pend_idx_in = scan_ff[ADDR_W-1:0];
      if (cmd.load) begin
         scan_in = '0;
      end else if (can_issue) begin
         scan_in = scan_ff + OCC_W'(1);
      end else begin
         scan_in = scan_ff;
      end
   end

   // Table writes: shift an entry down one slot, or append at the tail
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = occ_ff[ADDR_W-1:0];
      wr_data = elem_ff;
      if (cmd.shift && pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_idx_ff - ADDR_W'(1);
         wr_data = rd_data;
      end else if (cmd.append) begin
         wr_en = 1'b1;
      end
   end

   // Occupancy
   always_comb begin
      if (cmd.clear_occ) begin
         occ_in = '0;
      end else if (cmd.append) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (cmd.dec_occ) begin
         occ_in = occ_ff - OCC_W'(1);
      end else begin
         occ_in = occ_ff;
      end
   end

   // Request capture and per-request result
   always_comb begin
      act_in    = act_ff;
      elem_in   = elem_ff;
      found_in  = found_ff;
      status_in = status_ff;
      first_in  = first_ff;
      if (cmd.load) begin
         act_in    = req_action;
         elem_in   = ELEM_WIDTH'(req_elem);
         found_in  = 1'b0;
         status_in = iost_pkg::STAT_OK;
         first_in  = '0;
      end
      if (cmd.set_found) begin
         found_in = 1'b1;
      end
      if (cmd.set_full) begin
         status_in = iost_pkg::STAT_FULL;
      end
      if (cmd.mark_empty) begin
         status_in = iost_pkg::STAT_EMPTY;
      end
      if (cmd.take_first) begin
         first_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= '0;
         scan_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         occ_ff  <= occ_in;
         scan_ff <= scan_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      elem_ff     <= elem_in;
      pend_idx_ff <= pend_idx_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      first_ff    <= first_in;
      if (cmd.rsp_load) begin
         rsp_found_ff  <= found_ff;
         rsp_first_ff  <= PortW'(first_ff);
         rsp_count_ff  <= CountW'(occ_ff);
         rsp_empty_ff  <= (occ_ff == '0);
         rsp_status_ff <= status_ff;
      end
   end

   // Status to the controller
   always_comb begin
      sts.act       = act_ff;
      sts.hit       = pend_ff && (rd_data == elem_ff);
      sts.scan_done = !pend_ff && (scan_ff >= occ_ff);
      sts.full      = (occ_ff == OccFull);
      sts.occ_zero  = (occ_ff == '0);
   end

   assign rsp_found      = rsp_found_ff;
   assign rsp_first_elem = rsp_first_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_empty_res  = rsp_empty_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

@@ sv/insertion_ordered_set_table.sv @@
// Top level of the insertion-ordered set table (controller, datapath, table RAM).
//
// Requests (req_action, req_elem) enter on a valid/ready channel; each gives
// exactly one response (found, first_elem, count, empty_res, status) on the
// rsp_ valid/ready channel. One request is worked on at a time.
// Add, member and remove search the table from slot zero until a hit or the
// count; a remove hit then shifts the later entries down one slot. Get takes
// entry zero, read while idle; clear and unused actions go straight to the
// response. The single read port of the table RAM sets the pace: the search
// compares one entry per cycle and the shift moves one entry per cycle.
// A new request is taken the cycle after the previous one is loaded into
// the response register, and a stalled receiver holds at most one finished
// response while the next request is worked on.
// Reset (synchronous, active high) empties the set and drops rsp_valid;
// table contents are not cleared and are never read above the count.
// When the receiver stalls the response holds and a finished request
// waits in the controller until the response register frees.
`include "insertion_ordered_set_table_assert.svh"

module insertion_ordered_set_table #(
   parameter int CAPACITY   = iost_pkg::CAPACITY_DEF,
   parameter int ELEM_WIDTH = iost_pkg::ELEM_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [iost_pkg::ACTION_W-1:0]    req_action,
   input  logic [iost_pkg::ELEM_PORT_W-1:0] req_elem,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   output logic [iost_pkg::ELEM_PORT_W-1:0] rsp_first_elem,
   output logic [iost_pkg::COUNT_W-1:0]     rsp_count,
   output logic                             rsp_empty_res,
   output logic [iost_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int CountW = iost_pkg::COUNT_W;
   localparam logic [CountW-1:0] CapCount = CountW'(CAPACITY);

   iost_pkg::dp_cmd_type cmd;
   iost_pkg::dp_sts_type sts;

   // Shorthand terms for the checks
   logic req_take;
   logic rsp_full_st;
   logic rsp_empty_st;
   logic rsp_hit;
   logic rsp_at_cap;
   logic rsp_ok;
   logic rsp_no_elem;

   iost_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   iost_dp #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_elem       (req_elem),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_found      (rsp_found),
      .rsp_first_elem (rsp_first_elem),
      .rsp_count      (rsp_count),
      .rsp_empty_res  (rsp_empty_res),
      .rsp_status     (rsp_status)
   );

   assign req_take     = req_valid && req_ready;
   assign rsp_full_st  = rsp_valid && (rsp_status == iost_pkg::STAT_FULL);
   assign rsp_empty_st = rsp_valid && (rsp_status == iost_pkg::STAT_EMPTY);
   assign rsp_hit      = rsp_valid && rsp_found;
   assign rsp_at_cap   = (rsp_count == CapCount);
   assign rsp_ok       = (rsp_status == iost_pkg::STAT_OK);
   assign rsp_no_elem  = rsp_empty_res && (rsp_first_elem == '0);

   // One request in flight: no second acceptance right after one
   `IOST_ASSERT_NEXT(a_one_in_flight, clock, reset, req_take, !req_ready, "accepted while busy")
   // A refused add only happens with the table full
   `IOST_ASSERT_IMP(a_full_count, clock, reset, rsp_full_st, rsp_at_cap, "full status, not full")
   // A match never comes with an error status
   `IOST_ASSERT_IMP(a_found_ok, clock, reset, rsp_hit, rsp_ok, "found with error status")
   // Get on an empty set reports an empty set and no element
   `IOST_ASSERT_IMP(a_empty_get, clock, reset, rsp_empty_st, rsp_no_elem, "empty status mismatch")

endmodule

@@ tb/insertion_ordered_set_table_tb.sv @@
// Self-checking testbench for the insertion-ordered set table: driver, monitor and predictor.
`timescale 1ns / 100ps

module insertion_ordered_set_table_tb;

   localparam int SET_DEPTH   = iost_pkg::CAPACITY_DEF;
   localparam int POOL_SIZE   = 20;
   localparam int RANDOM_REQS = 1000;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_TAIL  = 40;

   // Action codes with no defined operation
   localparam logic [iost_pkg::ACTION_W-1:0] ACT_RSVD0 = 3'd5;
   localparam logic [iost_pkg::ACTION_W-1:0] ACT_RSVD1 = 3'd6;
   localparam logic [iost_pkg::ACTION_W-1:0] ACT_RSVD2 = 3'd7;

   // Receiver stall patterns
   localparam int STALL_NONE  = 0;
   localparam int STALL_SHORT = 1;
   localparam int STALL_LONG  = 2;

   typedef struct packed {
      logic [iost_pkg::ACTION_W-1:0]    action;
      logic [iost_pkg::ELEM_PORT_W-1:0] elem;
   } set_req_type;

   typedef struct packed {
      logic                             found;
      logic [iost_pkg::ELEM_PORT_W-1:0] first_elem;
      logic [iost_pkg::COUNT_W-1:0]     count;
      logic                             empty_res;
      logic [iost_pkg::STATUS_W-1:0]    status;
   } set_rsp_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [iost_pkg::ACTION_W-1:0]    req_action = '0;
   logic [iost_pkg::ELEM_PORT_W-1:0] req_elem = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_found;
   logic [iost_pkg::ELEM_PORT_W-1:0] rsp_first_elem;
   logic [iost_pkg::COUNT_W-1:0]     rsp_count;
   logic                             rsp_empty_res;
   logic [iost_pkg::STATUS_W-1:0]    rsp_status;

   insertion_ordered_set_table dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_elem       (req_elem),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_first_elem (rsp_first_elem),
      .rsp_count      (rsp_count),
      .rsp_empty_res  (rsp_empty_res),
      .rsp_status     (rsp_status)
   );

   set_req_type                      request_q[$];
   set_rsp_type                      expected_rsp_q[$];
   logic [iost_pkg::ELEM_PORT_W-1:0] set_slots[SET_DEPTH];
   int                               set_size = 0;
   logic [iost_pkg::ELEM_PORT_W-1:0] elem_pool[POOL_SIZE];
   int                               mismatches = 0;
   int                               cycle_count = 0;
   bit                               req_fire = 1'b0;
   int                               burst_left = 8;
   int                               gap_left = 0;
   int                               stall_left = 0;
   int                               stall_mode = STALL_NONE;
   int                               mode_left = 100;

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor: apply one request to the shadow set and return its response
   function automatic set_rsp_type apply_request(input set_req_type req);
      set_rsp_type rsp;
      int          hit;
      rsp = '0;
      hit = -1;
      for (int i = 0; i < set_size; i++) begin
         if (hit < 0 && set_slots[i] == req.elem) hit = i;
      end
      case (req.action)
         iost_pkg::ACT_ADD: begin
            if (hit >= 0) rsp.found = 1'b1;
            else if (set_size >= SET_DEPTH) rsp.status = iost_pkg::STAT_FULL;
            else begin
               set_slots[set_size] = req.elem;
               set_size++;
            end
         end
         iost_pkg::ACT_REMOVE: begin
            if (hit >= 0) begin
               rsp.found = 1'b1;
               // close the gap, keeping insertion order
               for (int i = hit; i < set_size - 1; i++) set_slots[i] = set_slots[i + 1];
               set_size--;
            end
         end
         iost_pkg::ACT_MEMBER: rsp.found = (hit >= 0);
         iost_pkg::ACT_GET: begin
            if (set_size == 0) rsp.status = iost_pkg::STAT_EMPTY;
            else rsp.first_elem = set_slots[0];
         end
         iost_pkg::ACT_CLEAR: set_size = 0;
         default: ;
      endcase
      rsp.count     = iost_pkg::COUNT_W'(set_size);
      rsp.empty_res = (set_size == 0);
      return rsp;
   endfunction

   task automatic push_request(input logic [iost_pkg::ACTION_W-1:0] action,
                               input logic [iost_pkg::ELEM_PORT_W-1:0] elem);
      set_req_type req;
      req.action = action;
      req.elem   = elem;
      request_q.push_back(req);
   endtask

   task automatic check_field(input string field,
                              input logic [iost_pkg::ELEM_PORT_W-1:0] want,
                              input logic [iost_pkg::ELEM_PORT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: rsp_%s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Random elements: mostly a small pool so adds collide and the set fills
   function automatic logic [iost_pkg::ELEM_PORT_W-1:0] pick_elem();
      if ($urandom_range(0, 6) == 0) return $urandom;
      return elem_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   function automatic logic [iost_pkg::ACTION_W-1:0] pick_action(input int mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         // fill: mostly adds
         0, 1, 2, 3: begin
            if (roll < 75) return iost_pkg::ACT_ADD;
            else if (roll < 85) return iost_pkg::ACT_MEMBER;
            else if (roll < 93) return iost_pkg::ACT_GET;
            else if (roll < 98) return iost_pkg::ACT_REMOVE;
            else return ACT_RSVD0;
         end
         // drain: mostly removes
         4, 5, 6: begin
            if (roll < 60) return iost_pkg::ACT_REMOVE;
            else if (roll < 75) return iost_pkg::ACT_MEMBER;
            else if (roll < 88) return iost_pkg::ACT_GET;
            else return iost_pkg::ACT_ADD;
         end
         // mixed: every code including the unused ones
         default: return iost_pkg::ACTION_W'($urandom_range(0, 7));
      endcase
   endfunction

   // Build the request list: directed cases first, then random rounds
   task automatic build_requests();
      int mode;
      int round_len;
      // empty set
      push_request(iost_pkg::ACT_GET, 32'h0000_0000);
      push_request(iost_pkg::ACT_REMOVE, 32'h0000_0005);
      push_request(iost_pkg::ACT_MEMBER, 32'h0000_0000);
      // extremes, duplicate add, hits and misses
      push_request(iost_pkg::ACT_ADD, 32'h0000_0000);
      push_request(iost_pkg::ACT_ADD, 32'hFFFF_FFFF);
      push_request(iost_pkg::ACT_ADD, 32'h0000_0000);
      push_request(iost_pkg::ACT_MEMBER, 32'hFFFF_FFFF);
      push_request(iost_pkg::ACT_MEMBER, 32'h0000_0001);
      push_request(iost_pkg::ACT_GET, 32'hFFFF_FFFF);
      push_request(iost_pkg::ACT_ADD, 32'h8000_0000);
      push_request(iost_pkg::ACT_ADD, 32'h0000_0001);
      // remove head, middle and tail; then an absent element
      push_request(iost_pkg::ACT_REMOVE, 32'h0000_0000);
      push_request(iost_pkg::ACT_GET, 32'h0000_0000);
      push_request(iost_pkg::ACT_REMOVE, 32'h8000_0000);
      push_request(iost_pkg::ACT_REMOVE, 32'h0000_0001);
      push_request(iost_pkg::ACT_REMOVE, 32'h1234_5678);
      // unused action codes leave the set alone
      push_request(ACT_RSVD0, 32'h5555_5555);
      push_request(ACT_RSVD1, 32'hAAAA_AAAA);
      push_request(ACT_RSVD2, 32'hFFFF_FFFF);
      // clear, then the empty cases again
      push_request(iost_pkg::ACT_CLEAR, 32'h0000_0000);
      push_request(iost_pkg::ACT_GET, 32'h0000_0000);
      push_request(iost_pkg::ACT_MEMBER, 32'hFFFF_FFFF);
      push_request(iost_pkg::ACT_ADD, 32'hAAAA_AAAA);
      push_request(iost_pkg::ACT_ADD, 32'h5555_5555);
      push_request(iost_pkg::ACT_CLEAR, 32'hFFFF_FFFF);

      // random rounds; the first one fills the set
      mode = 0;
      while (request_q.size() < RANDOM_REQS + 25) begin
         for (int i = 0; i < POOL_SIZE; i++) begin
            if ($urandom_range(0, 1) == 0) elem_pool[i] = $urandom_range(0, 31);
            else elem_pool[i] = $urandom;
         end
         round_len = $urandom_range(30, 60);
         if (mode == 9) push_request(iost_pkg::ACT_CLEAR, $urandom);
         for (int i = 0; i < round_len; i++) push_request(pick_action(mode), pick_elem());
         mode = $urandom_range(0, 9);
      end
   endtask

   // Request driver: bursts of back-to-back requests separated by gaps
   always @(negedge clock) begin
      set_req_type req;
      if (!reset) begin
         if (req_valid && !req_fire) begin
            // hold the request until it is taken
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (request_q.size() > 0) begin
            req = request_q.pop_front();
            req_valid  <= 1'b1;
            req_action <= req.action;
            req_elem   <= req.elem;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response receiver: ready pattern switches between no, short and long stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         case (stall_mode)
            STALL_SHORT: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
            STALL_LONG:  if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 30);
            default: ;
         endcase
      end
      mode_left--;
      if (mode_left <= 0) begin
         stall_mode = $urandom_range(STALL_NONE, STALL_LONG);
         mode_left  = $urandom_range(50, 300);
      end
   end

   // Monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      set_req_type req;
      set_rsp_type want;
      req_fire = !reset && req_valid && req_ready;
      if (req_fire) begin
         req.action = req_action;
         req.elem   = req_elem;
         expected_rsp_q.push_back(apply_request(req));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: response with none expected, actual count %0d status %0d",
                     $time, rsp_count, rsp_status);
            mismatches++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("found", want.found, rsp_found);
            check_field("first_elem", want.first_elem, rsp_first_elem);
            check_field("count", want.count, rsp_count);
            check_field("empty_res", want.empty_res, rsp_empty_res);
            check_field("status", want.status, rsp_status);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Test sequence
   initial begin
      build_requests();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (request_q.size() > 0 || req_valid) @(posedge clock);
      while (expected_rsp_q.size() > 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatches == 0 && expected_rsp_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ insertion_ordered_set_table.f @@
+incdir+sv
sv/iost_pkg.sv
sv/iost_ram.sv
sv/iost_ctrl.sv
sv/iost_dp.sv
sv/insertion_ordered_set_table.sv
tb/insertion_ordered_set_table_tb.sv
